### rtl/r2h_pkg.sv
// ----------------------------------------------------------------------------
// r2h_pkg: shared types and helpers for the rgb to hsv converter
// word layout of the divider chain, sector codes and the single divide step
// ----------------------------------------------------------------------------
package r2h_pkg;

    localparam int unsigned DIV_CELLS  = 17;   // quotient bits per lane
    localparam int unsigned SECTOR_SPAN = 60;
    localparam int unsigned GREEN_BASE = 120;
    localparam int unsigned BLUE_BASE  = 240;
    localparam int unsigned FULL_TURN  = 360;

    localparam logic [1:0] SECT_RED   = 2'd0;
    localparam logic [1:0] SECT_GREEN = 2'd1;
    localparam logic [1:0] SECT_BLUE  = 2'd2;

    // one restoring-division lane: remainder, divisor, numerator/quotient bits
    typedef struct packed {
        logic [7:0]  rem;
        logic [7:0]  den;
        logic [16:0] bits;
    } lane_t;

    typedef struct packed {
        logic [1:0] sector;
        logic       neg;
        logic       grey;
        logic       black;
        logic [7:0] value;
    } side_t;

    typedef struct packed {
        lane_t hue;
        lane_t sat;
        side_t side;
    } stage_t;

    // one quotient bit: numerator bits shift out at the top, quotient bits in at the bottom
    function automatic lane_t div_step(input lane_t cur);
        lane_t      nxt;
        logic [8:0] trial;
        logic       ge;
        trial = {cur.rem, cur.bits[16]};
        ge    = (trial >= {1'b0, cur.den});
        nxt.den  = cur.den;
        nxt.rem  = ge ? 8'(trial - {1'b0, cur.den}) : trial[7:0];
        nxt.bits = {cur.bits[15:0], ge};
        return nxt;
    endfunction

endpackage

### rtl/rgb_to_hsv_convert.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert: pipelined rgb to hsv pixel converter
// one packed rgb word in, one hue / saturation / value word out
// ----------------------------------------------------------------------------
// usage
//   input channel: pixel_color with pixel_valid / pixel_stall, red in bits
//   23:16, green 15:8, blue 7:0
//   output channel: hue_degrees (0..359), saturation_q16 (unsigned q1.16,
//   0..65536) and value_level (max channel) with result_valid / result_stall
//   path: from acceptance to result_valid a word passes the front cell,
//   the 17 divider cells (one quotient bit each) and the output register
//   throughput: one word per cycle when not stalled; every cell holds its own
//   valid bit, so bubbles close up and a new word enters while a result waits
//   reset: clears all valid bits, the pipeline comes up empty
//   receiver stall: the output register holds its word; cells behind it keep
//   filling until the chain is full, then pixel_stall rises
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert
    import r2h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  logic [23:0] pixel_color,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [8:0]  hue_degrees,
    output logic [16:0] saturation_q16,
    output logic [7:0]  value_level
);

    // chain links: index 0 is the front cell output, DIV_CELLS the last cell
    stage_t word  [0:DIV_CELLS];
    logic   valid [0:DIV_CELLS];
    logic   ready [0:DIV_CELLS];
    logic   front_ready;

    // front cell: max/min, sector and lane setup
    r2h_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pixel_valid),
        .up_ready (front_ready),
        .pixel    (pixel_color),
        .dn_valid (valid[0]),
        .dn_ready (ready[0]),
        .dn_word  (word[0])
    );

    assign pixel_stall = !front_ready;

    // divider chain, one quotient bit per cell for both lanes
    for (genvar i = 0; i < DIV_CELLS; i++)
    begin : g_cell
        r2h_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid[i]),
            .up_ready (ready[i]),
            .up_word  (word[i]),
            .dn_valid (valid[i+1]),
            .dn_ready (ready[i+1]),
            .dn_word  (word[i+1])
        );
    end

    // hue placement and output register
    r2h_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (valid[DIV_CELLS]),
        .up_ready  (ready[DIV_CELLS]),
        .up_word   (word[DIV_CELLS]),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .hue       (hue_degrees),
        .sat       (saturation_q16),
        .value     (value_level)
    );

    // hue stays on the circle
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (hue_degrees < 9'(FULL_TURN)))
        else $error("hue out of range");

    // a black pixel has no saturation, and saturation never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((value_level != 8'd0 || saturation_q16 == 17'd0)
                          && saturation_q16 <= 17'h10000))
        else $error("saturation out of range");

    // the saturation divider ends with a remainder below its divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid[DIV_CELLS] && !word[DIV_CELLS].side.black) |->
            (word[DIV_CELLS].sat.rem < word[DIV_CELLS].sat.den))
        else $error("divider remainder not below divisor");

    // the front cell never takes a word while the chain head is full and stuck
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid[0] && !ready[0]) |-> pixel_stall)
        else $error("input taken into a blocked chain");

endmodule

### rtl/r2h_prep.sv
// ----------------------------------------------------------------------------
// r2h_prep: front cell of the converter
// finds max, min and sector, and loads both divider lanes
// ----------------------------------------------------------------------------
module r2h_prep
    import r2h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  logic [23:0] pixel,
    output logic        dn_valid,
    input  logic        dn_ready,
    output stage_t      dn_word
);

    logic       valid_reg;
    stage_t     word_reg;
    stage_t     word_next;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] mx;
    logic [7:0] mn;
    logic [7:0] d;
    logic [8:0] num;
    logic [7:0] mag;
    logic [13:0] prod;

    assign r = pixel[23:16];
    assign g = pixel[15:8];
    assign b = pixel[7:0];

    always_comb
    begin
        mx = r;
        mn = r;
        if (g > mx)
            mx = g;
        if (b > mx)
            mx = b;
        if (g < mn)
            mn = g;
        if (b < mn)
            mn = b;
        d = mx - mn;

        // red wins ties, then green
        word_next.side.sector = SECT_BLUE;
        num = {1'b0, r} - {1'b0, g};
        if (mx == r)
        begin
            word_next.side.sector = SECT_RED;
            num = {1'b0, g} - {1'b0, b};
        end
        else if (mx == g)
        begin
            word_next.side.sector = SECT_GREEN;
            num = {1'b0, b} - {1'b0, r};
        end
        mag  = num[8] ? 8'(-num) : num[7:0];
        prod = 14'(mag * 14'(SECTOR_SPAN));

        word_next.side.neg   = num[8];
        word_next.side.grey  = (d == 8'd0);
        word_next.side.black = (mx == 8'd0);
        word_next.side.value = mx;

        // hue lane: 60*|num| / d, quotient fits in 6 bits
        word_next.hue.rem  = 8'd0;
        word_next.hue.den  = d;
        word_next.hue.bits = {3'd0, prod};

        // sat lane: (d << 16) / max, top bits pre-shifted into the remainder
        word_next.sat.rem  = {1'b0, d[7:1]};
        word_next.sat.den  = mx;
        word_next.sat.bits = {d[0], 16'd0};
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            word_reg <= word_next;
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

### rtl/r2h_div_cell.sv
// ----------------------------------------------------------------------------
// r2h_div_cell: one cell of the divider chain
// resolves one quotient bit of the hue and the saturation division
// ----------------------------------------------------------------------------
module r2h_div_cell
    import r2h_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    output logic   up_ready,
    input  stage_t up_word,
    output logic   dn_valid,
    input  logic   dn_ready,
    output stage_t dn_word
);

    logic   valid_reg;
    stage_t word_reg;
    stage_t word_next;

    always_comb
    begin
        word_next.hue  = div_step(up_word.hue);
        word_next.sat  = div_step(up_word.sat);
        word_next.side = up_word.side;
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            word_reg <= word_next;
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

### rtl/r2h_finish.sv
// ----------------------------------------------------------------------------
// r2h_finish: last cell and output register
// places the sector offset on the hue circle and applies grey / black cases
// ----------------------------------------------------------------------------
module r2h_finish
    import r2h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  stage_t      up_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [8:0]  hue,
    output logic [16:0] sat,
    output logic [7:0]  value
);

    logic        valid_reg;
    logic [8:0]  hue_reg;
    logic [8:0]  hue_next;
    logic [16:0] sat_reg;
    logic [16:0] sat_next;
    logic [7:0]  value_reg;
    logic [8:0]  q;
    logic [8:0]  base;

    always_comb
    begin
        q = {3'd0, up_word.hue.bits[5:0]};
        case (up_word.side.sector)
            SECT_GREEN: base = 9'(GREEN_BASE);
            SECT_BLUE:  base = 9'(BLUE_BASE);
            default:    base = 9'd0;
        endcase

        if (up_word.side.grey)
            hue_next = 9'd0;
        else if (!up_word.side.neg)
            hue_next = base + q;
        else if (up_word.side.sector != SECT_RED)
            hue_next = base - q;
        else if (q == 9'd0)
            hue_next = 9'd0;
        else
            hue_next = 9'(FULL_TURN) - q;

        sat_next = up_word.side.black ? 17'd0 : up_word.sat.bits;
    end

    assign up_ready = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            value_reg <= up_word.side.value;
        end
    end

    assign out_valid = valid_reg;
    assign hue       = hue_reg;
    assign sat       = sat_reg;
    assign value     = value_reg;

endmodule

### bench/rgb_to_hsv_convert_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_tb: self-checking bench for the rgb to hsv converter
// drives packed rgb words through the valid / stall input channel, predicts
// hue, saturation and value per word and compares every result word in order
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_tb;

    // hue arithmetic constants, signed so sector offsets truncate toward zero
    localparam int HUE_SECTOR  = 60;
    localparam int HUE_GREEN   = 120;
    localparam int HUE_BLUE    = 240;
    localparam int HUE_TURN    = 360;

    localparam int CLK_HALF    = 5;
    localparam int PIPE_DEPTH  = 19;       // acceptance to result_valid
    localparam int HOLD_CYCLES = 80;       // long receiver hold-off
    localparam int CYCLE_LIMIT = 200_000;

    typedef struct packed {
        logic [8:0]  hue;
        logic [16:0] sat;
        logic [7:0]  val;
    } hsv_word_t;

    logic        clk;
    logic        rst_n;
    logic        pixel_valid;
    logic        pixel_stall;
    logic [23:0] pixel_color;
    logic        result_valid;
    logic        result_stall;
    logic [8:0]  hue_degrees;
    logic [16:0] saturation_q16;
    logic [7:0]  value_level;

    hsv_word_t   hsv_expected_q[$];
    int          mismatch_count;
    int          cycle_count;

    // sender pacing: bursts of words with idle gaps in between
    bit          sender_gaps;
    int          burst_left;

    // set by a test, cleared by the receiver once the hold-off is over
    bit          hold_off_req;

    rgb_to_hsv_convert i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixel_valid    (pixel_valid),
        .pixel_stall    (pixel_stall),
        .pixel_color    (pixel_color),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .hue_degrees    (hue_degrees),
        .saturation_q16 (saturation_q16),
        .value_level    (value_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // hsv predictor
    // ------------------------------------------------------------------

    function automatic hsv_word_t rgb_hsv_predict(input logic [23:0] color);
        int        red;
        int        green;
        int        blue;
        int        hi;
        int        lo;
        int        span;
        int        hue;
        hsv_word_t word;
        red   = int'(color[23:16]);
        green = int'(color[15:8]);
        blue  = int'(color[7:0]);
        hi    = red;
        lo    = red;
        if (green > hi) hi = green;
        if (blue > hi) hi = blue;
        if (green < lo) lo = green;
        if (blue < lo) lo = blue;
        span = hi - lo;
        hue  = 0;
        // grey keeps hue 0; ties go red first, then green
        if (span != 0)
        begin
            if (hi == red)
                hue = ((HUE_SECTOR * (green - blue)) / span + HUE_TURN) % HUE_TURN;
            else if (hi == green)
                hue = (HUE_SECTOR * (blue - red)) / span + HUE_GREEN;
            else
                hue = (HUE_SECTOR * (red - green)) / span + HUE_BLUE;
        end
        word.hue = 9'(hue);
        // black pixel has no saturation
        word.sat = (hi == 0) ? 17'd0 : 17'((span << 16) / hi);
        word.val = 8'(hi);
        return word;
    endfunction

    // ------------------------------------------------------------------
    // result checker: every word taken from the output is matched against
    // the oldest prediction still waiting
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        hsv_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (hsv_expected_q.size() == 0)
            begin
                $error("result word with nothing expected: hue %0d sat %0d val %0d",
                       hue_degrees, saturation_q16, value_level);
                mismatch_count++;
            end
            else
            begin
                want = hsv_expected_q.pop_front();
                if (hue_degrees !== want.hue)
                begin
                    $error("hue_degrees: expected %0d, got %0d", want.hue, hue_degrees);
                    mismatch_count++;
                end
                if (saturation_q16 !== want.sat)
                begin
                    $error("saturation_q16: expected %0d, got %0d",
                           want.sat, saturation_q16);
                    mismatch_count++;
                end
                if (value_level !== want.val)
                begin
                    $error("value_level: expected %0d, got %0d", want.val, value_level);
                    mismatch_count++;
                end
            end
        end
    end

    // run limit, counted on the clock so a hung handshake cannot stall the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // receiver: stalls on its own pattern, switching between calm spells,
    // light and heavy random stalling and a toggling pattern; a test can
    // ask for one long hold-off so the pipeline fills and stalls its input
    // ------------------------------------------------------------------

    initial
    begin
        int stall_mode;
        int mode_left;
        int toggle;
        stall_mode = 0;
        mode_left  = 0;
        toggle     = 0;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
                result_stall <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 200);
                end
                mode_left--;
                toggle = ~toggle;
                case (stall_mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 3) == 0);
                    2:       result_stall <= ($urandom_range(0, 3) != 0);
                    default: result_stall <= toggle[0];
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // drop valid for some cycles; the color wanders while nothing is offered
    task automatic idle_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            pixel_valid <= 1'b0;
            pixel_color <= 24'($urandom);
        end
    endtask

    // offer one word, hold it until accepted, then record its prediction;
    // valid stays high afterwards so back-to-back words need no toggle
    task automatic send_pixel(input logic [23:0] color);
        if (sender_gaps)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                idle_sender($urandom_range(1, 6));
            end
            burst_left--;
        end
        @(negedge clk);
        pixel_valid <= 1'b1;
        pixel_color <= color;
        forever
        begin
            @(posedge clk);
            if (!pixel_stall)
                break;
        end
        hsv_expected_q.push_back(rgb_hsv_predict(color));
    endtask

    // random pixel with a lean toward the interesting corners
    function automatic logic [23:0] pick_pixel();
        logic [7:0] base;
        logic [7:0] top;
        logic [7:0] low;
        logic [7:0] ch [3];
        int         odd;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
                return 24'($urandom);
            5:
            begin
                // near grey: tiny spans give the coarsest division
                base = 8'($urandom_range(0, 250));
                return {8'(base + $urandom_range(0, 5)), 8'(base + $urandom_range(0, 5)),
                        8'(base + $urandom_range(0, 5))};
            end
            6:
            begin
                // two channels tie for the maximum
                top = 8'($urandom);
                low = 8'($urandom_range(0, top));
                odd = $urandom_range(0, 2);
                ch[0] = top;
                ch[1] = top;
                ch[2] = top;
                ch[odd] = low;
                return {ch[0], ch[1], ch[2]};
            end
            7:
            begin
                // channels pinned at the byte extremes, some left random
                ch[0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                ch[1] = $urandom_range(0, 1) ? 8'hFF : 8'($urandom);
                ch[2] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
                return {ch[$urandom_range(0, 2)], ch[1], ch[2]};
            end
            8:
                return {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                        8'($urandom_range(0, 3))};
            default:
                // one dominant channel, the others random below it
                return 24'($urandom) | (24'hFF << (8 * $urandom_range(0, 2)));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // primaries, ties, grey, black and negative sector offsets
    task automatic test_corner_pixels();
        sender_gaps = 1'b0;
        send_pixel(24'h000000);   // black: no saturation, no hue
        send_pixel(24'hFFFFFF);   // white
        send_pixel(24'h808080);   // mid grey
        send_pixel(24'h010101);   // darkest grey
        send_pixel(24'hFF0000);   // red
        send_pixel(24'h00FF00);   // green
        send_pixel(24'h0000FF);   // blue
        send_pixel(24'hFFFF00);   // red and green tie, red wins
        send_pixel(24'h00FFFF);   // green and blue tie, green wins
        send_pixel(24'hFF00FF);   // red and blue tie, red wins
        send_pixel(24'hFF0001);   // small negative red offset truncates to hue 0
        send_pixel(24'hFF0080);   // negative red offset wraps near 330
        send_pixel(24'hFF8000);   // positive red offset
        send_pixel(24'h80FF00);   // negative green offset
        send_pixel(24'h00FF80);   // positive green offset
        send_pixel(24'h0080FF);   // negative blue offset
        send_pixel(24'h8000FF);   // positive blue offset
        send_pixel(24'h010000);   // full saturation at the smallest max
        send_pixel(24'h000001);
        send_pixel(24'hFEFFFF);   // smallest nonzero span at full value
        send_pixel(24'hFFFEFE);
        send_pixel(24'h55AAFF);
        send_pixel(24'hFFFFFE);   // red and green tie over a nearly equal blue
    endtask

    task automatic test_random_pixels(input int count, input bit with_gaps);
        sender_gaps = with_gaps;
        burst_left  = 0;
        repeat (count)
            send_pixel(pick_pixel());
    endtask

    // receiver holds off while words keep coming, so the chain fills up
    // and the input has to stall until the hold-off ends
    task automatic test_input_backpressure();
        sender_gaps  = 1'b0;
        hold_off_req = 1'b1;
        repeat (HOLD_CYCLES) send_pixel(24'($urandom));
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        pixel_valid    = 1'b0;
        pixel_color    = 24'h000000;
        mismatch_count = 0;
        cycle_count    = 0;
        sender_gaps    = 1'b0;
        burst_left     = 0;
        hold_off_req   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_corner_pixels();
        test_random_pixels(400, 1'b1);
        test_input_backpressure();
        test_random_pixels(200, 1'b0);
        test_random_pixels(200, 1'b1);

        // stop offering, drain the pipeline, then give it time for strays
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (hsv_expected_q.size() != 0)
            @(posedge clk);
        repeat (2 * PIPE_DEPTH) @(posedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
